FILE: rtl/core/qat_pkg.sv
// Shared types and constants of the quoted argument tokenizer.
package qat_pkg;

	localparam int BUF_DEPTH = 256;
	localparam int POS_W = $clog2(BUF_DEPTH + 1);
	localparam logic [POS_W-1:0] BUF_FULL = POS_W'(BUF_DEPTH);

	localparam logic [1:0] KIND_CONTENT = 2'd0;
	localparam logic [1:0] KIND_TERM = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	localparam logic [6:0] MAX_ARGS_RST = 7'd60;
	localparam logic [5:0] LIMIT_SAT = 6'd63;

	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW = $clog2(OQ_DEPTH);

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_byte;
		logic [7:0] write_pos;
		logic [5:0] arg_index;
		logic [7:0] arg_start_pos;
		logic [5:0] arg_count;
		logic       truncated;
		logic       last;
	} qat_result_t;

	typedef struct packed {
		logic [1:0]  push_n;
		qat_result_t res0;
		qat_result_t res1;
	} qat_push_t;

endpackage

FILE: rtl/core/qat_outq.sv
// Result queue that takes up to two results per cycle and hands out one.
module qat_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  qat_pkg::qat_push_t push,
	output logic               room2,
	output logic               out_valid,
	input  logic               out_ready,
	output qat_pkg::qat_result_t out_res
);
	import qat_pkg::*;

	qat_result_t      mem_q [OQ_DEPTH];
	logic [OQ_AW-1:0] wr_ptr_q;
	logic [OQ_AW-1:0] rd_ptr_q;
	logic [OQ_AW:0]   count_q;
	logic             pop;
	logic [OQ_AW-1:0] wr_ptr_nxt;

	assign pop = out_valid && out_ready;
	assign out_valid = (count_q != '0);
	assign out_res = mem_q[rd_ptr_q];
	assign room2 = (count_q <= (OQ_AW+1)'(OQ_DEPTH - 2));
	assign wr_ptr_nxt = wr_ptr_q + OQ_AW'(1);

	always_ff @(posedge clk) begin
		if (push.push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= push.res0;
		end
		if (push.push_n == 2'd2) begin
			mem_q[wr_ptr_nxt] <= push.res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OQ_AW'(push.push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OQ_AW'(1);
			end
			count_q <= count_q + (OQ_AW+1)'(push.push_n) - (OQ_AW+1)'(pop);
		end
	end

endmodule

FILE: rtl/core/qat_ctrl.sv
// Input register, line state and per-byte tokenizing logic.
module qat_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic [6:0]         cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         in_char,
	input  logic               room2,
	output qat_pkg::qat_push_t push
);
	import qat_pkg::*;

	logic             valid_s1;
	logic [7:0]       char_s1;
	logic [6:0]       max_args_q;
	logic             in_quotes_q;
	logic             esc_q;
	logic             arg_open_q;
	logic             stopped_q;
	logic [5:0]       args_found_q;
	logic [POS_W-1:0] nwp_q;
	logic [7:0]       arg_start_q;
	logic             ovf_q;

	logic             in_quotes_d;
	logic             esc_d;
	logic             arg_open_d;
	logic             stopped_d;
	logic [5:0]       args_found_d;
	logic [POS_W-1:0] nwp_d;
	logic [7:0]       arg_start_d;
	logic             ovf_d;
	logic             process;
	logic [5:0]       limit;
	logic [6:0]       lim_raw;

	assign process = valid_s1 && room2;
	assign in_ready = !valid_s1 || process;
	assign lim_raw = max_args_q - 7'd1;

	always_comb begin
		if (max_args_q == 7'd0) begin
			limit = 6'd0;
		end else if (lim_raw > 7'(LIMIT_SAT)) begin
			limit = LIMIT_SAT;
		end else begin
			limit = lim_raw[5:0];
		end
	end

	always_comb begin
		logic [1:0]       n;
		logic [POS_W-1:0] pos;
		logic             do_end;
		logic             do_term;
		logic             do_content;
		qat_result_t      r0;
		qat_result_t      r1;
		qat_result_t      rt;
		qat_result_t      rc;
		qat_result_t      rd;

		in_quotes_d = in_quotes_q;
		esc_d = esc_q;
		arg_open_d = arg_open_q;
		stopped_d = stopped_q;
		args_found_d = args_found_q;
		nwp_d = nwp_q;
		arg_start_d = arg_start_q;
		ovf_d = ovf_q;
		n = 2'd0;
		pos = '0;
		do_end = 1'b0;
		do_term = 1'b0;
		do_content = 1'b0;
		r0 = '0;
		r1 = '0;
		rt = '0;
		rc = '0;
		rd = '0;

		priority if (stopped_q || max_args_q == 7'd0) begin
			do_end = (char_s1 == CH_NUL);
		end else if (esc_q) begin
			esc_d = 1'b0;
			if (char_s1 == CH_NUL) begin
				do_end = 1'b1;
			end else if (char_s1 == CH_QUOTE || char_s1 == CH_BSLASH) begin
				do_content = 1'b1;
			end
		end else if (char_s1 == CH_NUL) begin
			do_end = 1'b1;
		end else if (char_s1 == CH_SPACE && !in_quotes_q) begin
			if (arg_open_q) begin
				if (args_found_q >= limit) begin
					stopped_d = 1'b1;
				end else begin
					do_term = 1'b1;
				end
			end
		end else if (char_s1 == CH_QUOTE) begin
			in_quotes_d = !in_quotes_q;
		end else begin
			if (!arg_open_q) begin
				arg_open_d = 1'b1;
				arg_start_d = nwp_q[7:0];
			end
			if (char_s1 == CH_BSLASH) begin
				esc_d = 1'b1;
			end else begin
				do_content = 1'b1;
			end
		end

		if (do_end && !stopped_q && max_args_q != 7'd0 && arg_open_q
		    && args_found_q < limit) begin
			do_term = 1'b1;
		end

		if (do_content || do_term) begin
			pos = nwp_q;
			if (pos < BUF_FULL) begin
				nwp_d = pos + POS_W'(1);
			end else begin
				ovf_d = 1'b1;
			end
		end

		rc.kind = KIND_CONTENT;
		rc.out_byte = char_s1;
		rc.write_pos = pos[7:0];
		rc.truncated = ovf_d;

		rt.kind = KIND_TERM;
		rt.write_pos = pos[7:0];
		rt.arg_index = args_found_q;
		rt.arg_start_pos = arg_start_q;
		rt.truncated = ovf_d;

		if (do_term) begin
			args_found_d = args_found_q + 6'd1;
			arg_open_d = 1'b0;
		end

		rd.kind = KIND_DONE;
		rd.arg_count = args_found_d;
		rd.truncated = ovf_d;
		rd.last = 1'b1;

		if (do_end) begin
			if (do_term) begin
				r0 = rt;
				r1 = rd;
				n = 2'd2;
			end else begin
				r0 = rd;
				n = 2'd1;
			end
			in_quotes_d = 1'b0;
			esc_d = 1'b0;
			arg_open_d = 1'b0;
			stopped_d = 1'b0;
			args_found_d = '0;
			nwp_d = '0;
			arg_start_d = '0;
			ovf_d = 1'b0;
		end else if (do_term) begin
			r0 = rt;
			r0.last = 1'b1;
			n = 2'd1;
		end else if (do_content) begin
			r0 = rc;
			r0.last = 1'b1;
			n = 2'd1;
		end

		push.push_n = process ? n : 2'd0;
		push.res0 = r0;
		push.res1 = r1;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= in_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			max_args_q <= MAX_ARGS_RST;
			in_quotes_q <= 1'b0;
			esc_q <= 1'b0;
			arg_open_q <= 1'b0;
			stopped_q <= 1'b0;
			args_found_q <= '0;
			nwp_q <= '0;
			arg_start_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (cfg_wen) begin
				max_args_q <= cfg_wdata;
			end
			if (process) begin
				in_quotes_q <= in_quotes_d;
				esc_q <= esc_d;
				arg_open_q <= arg_open_d;
				stopped_q <= stopped_d;
				args_found_q <= args_found_d;
				nwp_q <= nwp_d;
				arg_start_q <= arg_start_d;
				ovf_q <= ovf_d;
			end
		end
	end

endmodule

FILE: rtl/core/quoted_argument_tokenizer.sv
// Top level of the quoted argument tokenizer.
//
// The slave channel takes one byte of a command line per item; a zero byte
// ends the line. The master channel returns records: a content byte with its
// buffer position, an argument terminator with index and start position, or
// a line finished record with the argument count. tuser carries the kind and
// tlast marks the final record caused by one input byte.
// An accepted byte is held in the input register and decoded there; its
// records are written into the result queue, from which they are offered.
// The block takes one byte per cycle while the queue has two free entries;
// the end of a line that closes an open argument gives two records, and then
// the output channel, at one record per cycle, sets the pace.
// The records go through a four-entry queue. When the receiver stalls, the
// queue fills and tready on the slave side drops while a byte waits in the
// input register and fewer than two entries are free. Reset empties the
// queue, clears the line state and sets the argument slot register to 60.
// cfg_wen writes that register directly.
module quoted_argument_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [6:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // char_in[7:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_byte[7:0], write_pos[15:8], arg_index[21:16], arg_start_pos[29:22],
	// arg_count[35:30], truncated[36], zero[39:37]
	output logic [39:0] m_tdata,
	output logic [1:0]  m_tuser,   // kind[1:0]
	output logic        m_tlast
);
	import qat_pkg::*;

	qat_push_t   push;
	qat_result_t res;
	logic        room2;

	qat_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_char   (s_tdata),
		.room2     (room2),
		.push      (push)
	);

	qat_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room2     (room2),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = {3'b000, res.truncated, res.arg_count, res.arg_start_pos,
	                  res.arg_index, res.write_pos, res.out_byte};
	assign m_tuser = res.kind;
	assign m_tlast = res.last;

endmodule

FILE: rtl/core/qat_checker.sv
// Port-level checks of the quoted argument tokenizer and their binding.
module qat_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);
	import qat_pkg::*;

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("Result valid dropped while stalled.");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == KIND_CONTENT || m_tuser == KIND_TERM
		              || m_tuser == KIND_DONE))
		else $error("Illegal record kind.");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_DONE |-> m_tlast && m_tdata[29:0] == '0)
		else $error("Line finished record malformed.");

	a_term_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_TERM |-> m_tdata[7:0] == '0
		                                     && m_tdata[35:30] == '0)
		else $error("Terminator record malformed.");

endmodule

bind quoted_argument_tokenizer qat_checker u_qat_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
